[hw/rtl/text_console_scrollback_macros.svh]
// Assertion macros for the text console scrollback block.
// Taken in by the modules that check their own control logic; no other dependency.
`ifndef TEXT_CONSOLE_SCROLLBACK_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define TCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcs: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcs: next-cycle check failed");

`endif

[hw/rtl/tcs_pkg.sv]
// Shared constants and types of the text console scrollback block.
// No dependencies; imported by the controller and the top level.
package tcs_pkg;

	localparam int STORE_ROWS  = 512;
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELLS       = STORE_ROWS * SCREEN_COLS;

	localparam int ROW_W  = $clog2(STORE_ROWS);
	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int MEM_AW = $clog2(CELLS);

	localparam int CELL_W = 16;
	localparam int CUR_W  = 11;
	localparam int OP_W   = 3;
	localparam int CHAR_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int ATTR_W = 8;
	localparam int ADDR_W = 3;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1E;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [CHAR_W-1:0] char_code;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_column;
	} tcs_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [CUR_W-1:0]  cursor_pos;
		logic [ROW_W-1:0]  view_top;
		logic [ROW_W-1:0]  write_row;
		logic [COL_W-1:0]  write_column;
	} tcs_result_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [MEM_AW-1:0] addr;
		logic [CELL_W-1:0] wdata;
	} tcs_ram_req_t;

endpackage

[hw/rtl/tcs_cell_ram.sv]
// Single-port synchronous cell memory, registered read.
// Generic; no package dependency.
module tcs_cell_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[hw/rtl/tcs_ctrl.sv]
// Sequencer of the console: cursor, view and ring state, and the memory access steps.
// Depends on tcs_pkg and the assertion macros header.
`include "text_console_scrollback_macros.svh"

module tcs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  tcs_pkg::tcs_item_t        item,
	output logic                      item_ready,
	input  logic [tcs_pkg::ATTR_W-1:0] attr,
	input  logic                      res_ready,
	output logic                      res_push,
	output tcs_pkg::tcs_result_t      res,
	output tcs_pkg::tcs_ram_req_t     ram_req,
	input  logic [tcs_pkg::CELL_W-1:0] ram_rdata
);
	import tcs_pkg::*;

	localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
	localparam logic [OP_W-1:0] OP_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_FWD   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

	localparam logic [3:0] ST_SWEEP   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_EXEC    = 4'd2;
	localparam logic [3:0] ST_PHYS    = 4'd3;
	localparam logic [3:0] ST_ADDR    = 4'd4;
	localparam logic [3:0] ST_MEM     = 4'd5;
	localparam logic [3:0] ST_RWAIT   = 4'd6;
	localparam logic [3:0] ST_NEWLINE = 4'd7;
	localparam logic [3:0] ST_FINISH  = 4'd8;
	localparam logic [3:0] ST_CURSOR  = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_BLANK = 2'd2;

	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(STORE_ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
	localparam logic [ROW_W-1:0]  FOLLOW_GAP = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [MEM_AW-1:0] LAST_CELL = MEM_AW'(CELLS - 1);

	logic [3:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] char_q;
	logic [RROW_W-1:0] rrow_q;
	logic [RCOL_W-1:0] rcol_q;
	logic [ROW_W-1:0]  ring_q;
	logic [ROW_W-1:0]  line_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  view_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [ROW_W-1:0]  acc_row_q;
	logic [COL_W-1:0]  acc_col_q;
	logic [1:0]        kind_q;
	logic              nl_pend_q;
	logic [CELL_W-1:0] wdata_q;
	logic [CELL_W-1:0] blank_q;
	logic [ROW_W-1:0]  phys_q;
	logic [MEM_AW-1:0] mem_addr_q;
	logic [CELL_W-1:0] cell_q;
	logic              sweep_clear_q;
	logic [COL_W-1:0]  blank_cnt_q;

	logic [ROW_W-1:0]  follow_lim;
	logic [ROW_W:0]    logical;
	logic [ROW_W:0]    phys_sum;
	logic [ROW_W-1:0]  phys_next;
	logic [MEM_AW-1:0] addr_next;
	logic [CUR_W-1:0]  diff;
	logic [CUR_W-1:0]  cursor_next;
	logic [CELL_W-1:0] blank_cur;

	always_comb begin
		follow_lim  = (line_q >= FOLLOW_GAP) ? line_q - FOLLOW_GAP : '0;
		logical     = {1'b0, view_q} + (ROW_W + 1)'(rrow_q);
		phys_sum    = {1'b0, ring_q} + {1'b0, acc_row_q};
		phys_next   = (phys_sum >= (ROW_W + 1)'(STORE_ROWS)) ?
			ROW_W'(phys_sum - (ROW_W + 1)'(STORE_ROWS)) : ROW_W'(phys_sum);
		addr_next   = MEM_AW'(32'(phys_q) * SCREEN_COLS) + MEM_AW'(acc_col_q);
		// screen row wraps modulo the cursor width when the view sits below the line
		diff        = CUR_W'(line_q) - CUR_W'(view_q);
		cursor_next = CUR_W'(32'(diff) * SCREEN_COLS) + CUR_W'(col_q);
		blank_cur   = {attr, CH_SPACE};
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_push   = (state_q == ST_DONE) && res_ready;

	always_comb begin
		res.cell_data    = cell_q;
		res.cursor_pos   = cursor_q;
		res.view_top     = view_q;
		res.write_row    = line_q;
		res.write_column = col_q;
	end

	always_comb begin
		ram_req.we    = (state_q == ST_SWEEP) || ((state_q == ST_MEM) && (kind_q != KIND_READ));
		ram_req.re    = (state_q == ST_MEM) && (kind_q == KIND_READ);
		ram_req.addr  = mem_addr_q;
		ram_req.wdata = (state_q == ST_SWEEP) ? blank_q : wdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			ring_q        <= '0;
			line_q        <= '0;
			col_q         <= '0;
			view_q        <= '0;
			cursor_q      <= '0;
			mem_addr_q    <= '0;
			blank_q       <= {ATTR_RESET, CH_SPACE};
			sweep_clear_q <= 1'b0;
			nl_pend_q     <= 1'b0;
			kind_q        <= KIND_WRITE;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					mem_addr_q <= mem_addr_q + 1'b1;
					if (mem_addr_q == LAST_CELL) begin
						state_q       <= sweep_clear_q ? ST_DONE : ST_IDLE;
						sweep_clear_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						op_q    <= item.opcode;
						char_q  <= item.char_code;
						rrow_q  <= item.read_row;
						rcol_q  <= item.read_column;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cell_q    <= '0;
					nl_pend_q <= 1'b0;
					unique case (op_q)
						OP_PUT: begin
							if (char_q == CH_BACKSPACE) begin
								// step back, across a line start if needed, and blank
								if (col_q != '0) begin
									col_q     <= col_q - 1'b1;
									acc_row_q <= line_q;
									acc_col_q <= col_q - 1'b1;
								end else if (line_q != '0) begin
									line_q    <= line_q - 1'b1;
									col_q     <= LAST_COL;
									acc_row_q <= line_q - 1'b1;
									acc_col_q <= LAST_COL;
								end else begin
									acc_row_q <= line_q;
									acc_col_q <= col_q;
								end
								wdata_q <= blank_cur;
								kind_q  <= KIND_WRITE;
								state_q <= ST_PHYS;
							end else if (char_q == CH_NEWLINE) begin
								state_q <= ST_NEWLINE;
							end else begin
								acc_row_q <= line_q;
								acc_col_q <= col_q;
								wdata_q   <= {attr, char_q};
								kind_q    <= KIND_WRITE;
								if (col_q == LAST_COL) begin
									nl_pend_q <= 1'b1;
								end else begin
									col_q <= col_q + 1'b1;
								end
								state_q <= ST_PHYS;
							end
						end
						OP_BACK: begin
							if (view_q != '0) begin
								view_q <= view_q - 1'b1;
							end
							state_q <= ST_DONE;
						end
						OP_FWD: begin
							if (view_q < follow_lim) begin
								view_q <= view_q + 1'b1;
							end
							state_q <= ST_DONE;
						end
						OP_CLEAR: begin
							blank_q       <= blank_cur;
							ring_q        <= '0;
							line_q        <= '0;
							col_q         <= '0;
							view_q        <= '0;
							cursor_q      <= '0;
							mem_addr_q    <= '0;
							sweep_clear_q <= 1'b1;
							state_q       <= ST_SWEEP;
						end
						OP_READ: begin
							if ((32'(rrow_q) < SCREEN_ROWS) && (32'(rcol_q) < SCREEN_COLS)) begin
								if (logical < (ROW_W + 1)'(STORE_ROWS)) begin
									acc_row_q <= ROW_W'(logical);
									acc_col_q <= COL_W'(rcol_q);
									kind_q    <= KIND_READ;
									state_q   <= ST_PHYS;
								end else begin
									cell_q  <= blank_cur;
									state_q <= ST_DONE;
								end
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_PHYS: begin
					phys_q  <= phys_next;
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					mem_addr_q  <= addr_next;
					blank_cnt_q <= '0;
					state_q     <= ST_MEM;
				end
				ST_MEM: begin
					unique case (kind_q)
						KIND_WRITE: begin
							state_q <= nl_pend_q ? ST_NEWLINE : ST_FINISH;
						end
						KIND_READ: begin
							state_q <= ST_RWAIT;
						end
						default: begin
							// blank the new bottom row one cell a cycle
							mem_addr_q  <= mem_addr_q + 1'b1;
							blank_cnt_q <= blank_cnt_q + 1'b1;
							if (blank_cnt_q == LAST_COL) begin
								state_q <= ST_FINISH;
							end
						end
					endcase
				end
				ST_RWAIT: begin
					cell_q  <= ram_rdata;
					state_q <= ST_DONE;
				end
				ST_NEWLINE: begin
					col_q     <= '0;
					nl_pend_q <= 1'b0;
					if (line_q == LAST_ROW) begin
						// store full: advance the ring and blank the reused row
						ring_q    <= (ring_q == LAST_ROW) ? '0 : ring_q + 1'b1;
						acc_row_q <= LAST_ROW;
						acc_col_q <= '0;
						wdata_q   <= blank_cur;
						kind_q    <= KIND_BLANK;
						state_q   <= ST_PHYS;
					end else begin
						line_q  <= line_q + 1'b1;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (view_q < follow_lim) begin
						view_q <= follow_lim;
					end
					state_q <= ST_CURSOR;
				end
				ST_CURSOR: begin
					cursor_q <= cursor_next;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TCS_ASSERT_IMPL(a_col_in_range, clk, arst_n, 1'b1, col_q <= LAST_COL)
	`TCS_ASSERT_IMPL(a_view_follows, clk, arst_n, state_q == ST_CURSOR, view_q >= follow_lim)
	`TCS_ASSERT_IMPL(a_rwait_after_read, clk, arst_n, state_q == ST_RWAIT, $past(ram_req.re))
	`TCS_ASSERT_NEXT(a_push_to_idle, clk, arst_n, res_push, state_q == ST_IDLE)

endmodule

[hw/rtl/text_console_scrollback.sv]
// Top level of the text console scrollback block: ports, attribute register, result register.
// Depends on tcs_pkg, tcs_cell_ram and tcs_ctrl.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      opcode, char_code, read_row, read_column
//   result    out        result_valid / result_stall  cell_data, cursor_pos, view_top,
//                                                     write_row, write_column
//   config    in         psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// One item at a time through the controller; the next item is taken once the result is pushed.
// Clear sweeps all STORE_ROWS*SCREEN_COLS cells through the single memory port.
// After reset the same sweep runs with the reset attribute; item_stall stays high meanwhile.
// A finished result waits in the output register, so the next item is taken while it is stalled.
module text_console_scrollback (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [tcs_pkg::OP_W-1:0]    opcode,
	input  logic [tcs_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcs_pkg::RROW_W-1:0]  read_row,
	input  logic [tcs_pkg::RCOL_W-1:0]  read_column,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [tcs_pkg::CELL_W-1:0]  cell_data,
	output logic [tcs_pkg::CUR_W-1:0]   cursor_pos,
	output logic [tcs_pkg::ROW_W-1:0]   view_top,
	output logic [tcs_pkg::ROW_W-1:0]   write_row,
	output logic [tcs_pkg::COL_W-1:0]   write_column,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tcs_pkg::*;

	localparam logic REG_TEXT_ATTR = 1'b0;

	logic [ATTR_W-1:0] attr_q;
	tcs_item_t         item;
	logic              item_ready;
	logic              res_ready;
	logic              res_push;
	tcs_result_t       res;
	tcs_result_t       res_q;
	logic              result_valid_q;
	tcs_ram_req_t      ram_req;
	logic [CELL_W-1:0] ram_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {{(32 - ATTR_W){1'b0}}, attr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR)) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	always_comb begin
		item.opcode      = opcode;
		item.char_code   = char_code;
		item.read_row    = read_row;
		item.read_column = read_column;
	end

	assign item_stall = !item_ready;
	assign res_ready  = !result_valid_q || !result_stall;

	tcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.attr       (attr_q),
		.res_ready  (res_ready),
		.res_push   (res_push),
		.res        (res),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	tcs_cell_ram #(
		.DEPTH (CELLS),
		.WIDTH (CELL_W)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.re    (ram_req.re),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// hold the result until taken; load a new one as the old leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_push) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign cell_data    = res_q.cell_data;
	assign cursor_pos   = res_q.cursor_pos;
	assign view_top     = res_q.view_top;
	assign write_row    = res_q.write_row;
	assign write_column = res_q.write_column;

endmodule

[dv/text_console_scrollback_test.sv]
// Self-checking testbench for text_console_scrollback: directed table, then random phases.
// Keeps its own shadow of the scrollback store to predict each result; needs tcs_pkg and the RTL.
module text_console_scrollback_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcs_pkg::*;

	typedef enum logic [OP_W-1:0] {
		OP_PUT_CHAR     = 3'd0,
		OP_VIEW_BACK    = 3'd1,
		OP_VIEW_FORWARD = 3'd2,
		OP_CLEAR        = 3'd3,
		OP_READ_CELL    = 3'd4,
		OP_SPARE_A      = 3'd5,
		OP_SPARE_B      = 3'd6,
		OP_SPARE_C      = 3'd7
	} console_op_e;

	localparam logic [ADDR_W-1:0] REG_TEXT_ATTRIBUTE = 3'd0;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam int SCROLL_GOAL = 6;
	localparam int PHASE_ITEMS = 12;

	typedef struct {
		console_op_e       op;
		logic [CHAR_W-1:0] ch;
		logic [RROW_W-1:0] row;
		logic [RCOL_W-1:0] col;
	} console_item_t;

	typedef struct {
		console_item_t item;
		bit            golden;
		tcs_result_t   want;
	} step_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [OP_W-1:0]    opcode = '0;
	logic [CHAR_W-1:0]  char_code = '0;
	logic [RROW_W-1:0]  read_row = '0;
	logic [RCOL_W-1:0]  read_column = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [CELL_W-1:0]  cell_data;
	logic [CUR_W-1:0]   cursor_pos;
	logic [ROW_W-1:0]   view_top;
	logic [ROW_W-1:0]   write_row;
	logic [COL_W-1:0]   write_column;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	text_console_scrollback dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.opcode(opcode), .char_code(char_code), .read_row(read_row), .read_column(read_column),
		.result_valid(result_valid), .result_stall(result_stall),
		.cell_data(cell_data), .cursor_pos(cursor_pos), .view_top(view_top),
		.write_row(write_row), .write_column(write_column),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the console state
	bit [CELL_W-1:0]   shadow_cells [CELLS];
	logic [ATTR_W-1:0] shadow_attr;
	int unsigned       shadow_base, shadow_line, shadow_col, shadow_view, shadow_cursor;

	tcs_result_t pending_results [$];
	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int store_scrolls = 0;
	int attr_writes = 0;
	int clears_left = 2;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic bit [CELL_W-1:0] blank_word();
		return {shadow_attr, CH_SPACE};
	endfunction

	function automatic int unsigned cell_index(int unsigned row, int unsigned col);
		return ((shadow_base + row % STORE_ROWS) % STORE_ROWS) * SCREEN_COLS + col % SCREEN_COLS;
	endfunction

	function automatic void wipe_store();
		bit [CELL_W-1:0] b;
		b = blank_word();
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = b;
	endfunction

	function automatic void advance_line();
		shadow_col = 0;
		shadow_line++;
		if (shadow_line >= STORE_ROWS) begin
			// store full: rotate the ring and blank the new bottom line
			shadow_base = (shadow_base + 1) % STORE_ROWS;
			shadow_line = STORE_ROWS - 1;
			store_scrolls++;
			for (int x = 0; x < SCREEN_COLS; x++)
				shadow_cells[cell_index(shadow_line, x)] = blank_word();
		end
	endfunction

	function automatic int unsigned follow_limit();
		return (shadow_line >= SCREEN_ROWS - 1) ? shadow_line - (SCREEN_ROWS - 1) : 0;
	endfunction

	function automatic tcs_result_t console_step(console_item_t it);
		tcs_result_t r;
		int unsigned logical;
		bit [31:0] lin;
		r = '0;
		case (it.op)
			OP_PUT_CHAR: begin
				if (it.ch == CH_BACKSPACE) begin
					if (shadow_col > 0) begin
						shadow_col--;
					end else if (shadow_line > 0) begin
						shadow_line--;
						shadow_col = SCREEN_COLS - 1;
					end
					shadow_cells[cell_index(shadow_line, shadow_col)] = blank_word();
				end else if (it.ch == CH_NEWLINE) begin
					advance_line();
				end else begin
					shadow_cells[cell_index(shadow_line, shadow_col)] = {shadow_attr, it.ch};
					shadow_col++;
					if (shadow_col >= SCREEN_COLS)
						advance_line();
				end
				if (shadow_view < follow_limit())
					shadow_view = follow_limit();
				// screen row may go negative after a backspace; let it wrap
				lin = (shadow_line - shadow_view) * SCREEN_COLS + shadow_col;
				shadow_cursor = lin[CUR_W-1:0];
			end
			OP_VIEW_BACK: begin
				if (shadow_view > 0)
					shadow_view--;
			end
			OP_VIEW_FORWARD: begin
				if (shadow_view < follow_limit())
					shadow_view++;
			end
			OP_CLEAR: begin
				wipe_store();
				shadow_base = 0;
				shadow_line = 0;
				shadow_col = 0;
				shadow_view = 0;
				shadow_cursor = 0;
			end
			OP_READ_CELL: begin
				if (it.row < SCREEN_ROWS && it.col < SCREEN_COLS) begin
					logical = shadow_view + it.row;
					r.cell_data = (logical < STORE_ROWS) ?
						shadow_cells[cell_index(logical, it.col)] : blank_word();
				end
			end
			default: ;
		endcase
		r.cursor_pos   = shadow_cursor[CUR_W-1:0];
		r.view_top     = shadow_view[ROW_W-1:0];
		r.write_row    = shadow_line[ROW_W-1:0];
		r.write_column = shadow_col[COL_W-1:0];
		return r;
	endfunction

	function automatic console_item_t random_item(bit store_fill);
		console_item_t it;
		int pick;
		it.op  = OP_PUT_CHAR;
		it.ch  = CHAR_W'($urandom_range(0, 255));
		it.row = ($urandom_range(0, 9) == 0) ? RROW_W'($urandom_range(0, 31)) :
			RROW_W'($urandom_range(0, 24));
		it.col = ($urandom_range(0, 9) == 0) ? RCOL_W'($urandom_range(0, 127)) :
			RCOL_W'($urandom_range(0, 79));
		pick = $urandom_range(0, 99);
		if (store_fill) begin
			if (pick < 95)
				it.ch = CH_NEWLINE;
			else if (pick < 96)
				it.op = OP_PUT_CHAR;
			else if (pick < 97)
				it.ch = CH_BACKSPACE;
			else if (pick < 98)
				it.op = OP_READ_CELL;
			else
				it.op = pick[0] ? OP_VIEW_BACK : OP_VIEW_FORWARD;
		end else begin
			if (pick < 12)
				it.ch = CH_NEWLINE;
			else if (pick < 20)
				it.ch = CH_BACKSPACE;
			else if (pick < 55)
				it.op = OP_PUT_CHAR;
			else if (pick < 78)
				it.op = OP_READ_CELL;
			else if (pick < 86)
				it.op = OP_VIEW_BACK;
			else if (pick < 94)
				it.op = OP_VIEW_FORWARD;
			else if (pick < 98)
				it.op = console_op_e'($urandom_range(5, 7));
			else if (clears_left > 0) begin
				it.op = OP_CLEAR;
				clears_left--;
			end else
				it.op = OP_READ_CELL;
		end
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(console_item_t it, bit golden, tcs_result_t want);
		tcs_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		opcode      <= it.op;
		char_code   <= it.ch;
		read_row    <= it.row;
		read_column <= it.col;
		do @(posedge clk); while (item_stall !== 1'b0);
		predicted = console_step(it);
		pending_results.push_back(golden ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write the attribute register, then read it back.
	task automatic write_attribute(logic [ATTR_W-1:0] value);
		logic [31:0] word;
		word = $urandom();
		word[ATTR_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_TEXT_ATTRIBUTE;
		pwdata  <= word;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {24'h0, value}) begin
			error_count++;
			$display("%0t: text_attribute readback expected %0h got %0h", $time, value, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		shadow_attr = value;
		attr_writes++;
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int count, int scroll_goal,
			bit store_fill);
		int sent;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < count || store_scrolls < scroll_goal) begin
			// hold off once mid-phase until the block has answered everything
			if (sent == count / 2)
				wait_for_results();
			send_item(random_item(store_fill), 1'b0, '0);
			sent++;
		end
		wait_for_results();
	endtask

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		tcs_result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result with no item outstanding, cell_data %0h", $time,
					cell_data);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("cell_data", want.cell_data, cell_data);
				check_field("cursor_pos", want.cursor_pos, cursor_pos);
				check_field("view_top", want.view_top, view_top);
				check_field("write_row", want.write_row, write_row);
				check_field("write_column", want.write_column, write_column);
			end
		end
	end

	localparam int DIRECTED_ROWS = 24;
	step_row_t directed_steps [DIRECTED_ROWS] = '{
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd0},   1'b1, '{16'h1E20, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_READ_CELL,    8'h00, 5'd24, 7'd79},  1'b1, '{16'h1E20, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_READ_CELL,    8'h00, 5'd25, 7'd0},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_READ_CELL,    8'hFF, 5'd31, 7'd127}, 1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd80},  1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_SPARE_A,      8'hFF, 5'd31, 7'd127}, 1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_SPARE_C,      8'h41, 5'd1,  7'd1},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_VIEW_BACK,    8'h00, 5'd0,  7'd0},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_VIEW_FORWARD, 8'h00, 5'd0,  7'd0},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_PUT_CHAR,     8'h08, 5'd0,  7'd0},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_PUT_CHAR,     8'h41, 5'd0,  7'd0},   1'b1, '{16'h0000, 11'd1, 9'd0, 9'd0, 7'd1}},
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd0},   1'b1, '{16'h1E41, 11'd1, 9'd0, 9'd0, 7'd1}},
		'{'{OP_PUT_CHAR,     8'hFF, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h00, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h1B, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd1},   1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h08, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h0A, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h08, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd79},  1'b0, '0},
		'{'{OP_PUT_CHAR,     8'h80, 5'd0,  7'd0},   1'b0, '0},
		'{'{OP_CLEAR,        8'h00, 5'd0,  7'd0},   1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_READ_CELL,    8'h00, 5'd0,  7'd0},   1'b1, '{16'h1E20, 11'd0, 9'd0, 9'd0, 7'd0}},
		'{'{OP_SPARE_B,      8'h7F, 5'd16, 7'd64},  1'b1, '{16'h0000, 11'd0, 9'd0, 9'd0, 7'd0}}
	};

	initial begin
		shadow_attr = ATTR_RESET;
		shadow_base = 0;
		shadow_line = 0;
		shadow_col = 0;
		shadow_view = 0;
		shadow_cursor = 0;
		wipe_store();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_steps[i])
			send_item(directed_steps[i].item, directed_steps[i].golden, directed_steps[i].want);
		wait_for_results();

		write_attribute(8'hFF);
		run_phase(0, 0, PHASE_ITEMS, 0, 1'b0);
		write_attribute(8'h00);
		run_phase(71, 0, PHASE_ITEMS, 0, 1'b0);
		write_attribute(ATTR_W'($urandom_range(1, 254)));
		run_phase(0, 71, PHASE_ITEMS, 0, 1'b0);
		write_attribute(ATTR_W'($urandom_range(1, 254)));
		run_phase(25, 25, PHASE_ITEMS, 0, 1'b0);

		// mostly newlines: fill the store and make it scroll several times
		write_attribute(ATTR_W'($urandom_range(0, 255)));
		run_phase(25, 25, 0, SCROLL_GOAL, 1'b1);

		// clear with the ring rotated, then write over the fresh store
		write_attribute(ATTR_W'($urandom_range(0, 255)));
		send_idle_pct = 0;
		send_item('{OP_CLEAR, 8'h00, 5'd0, 7'd0}, 1'b0, '0);
		run_phase(0, 71, PHASE_ITEMS, 0, 1'b0);

		repeat (100) @(posedge clk);
		$display("Ran %0d items (%0d results checked) over six idle phases", items_sent,
			results_checked);
		$display("Store scrolled %0d times; attribute written %0d times", store_scrolls,
			attr_writes);
		if (error_count == 0) begin
			$display("text_console_scrollback verification clean");
		end else begin
			$display("text_console_scrollback verification failed");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("text_console_scrollback verification failed");
		$finish;
	end

endmodule
